// ----- rtl/core/repeating_timer_queue_top_defines.svh -----
// Assertion macros for the repeating timer queue.
`ifndef REPEATING_TIMER_QUEUE_TOP_DEFINES_SVH
`define REPEATING_TIMER_QUEUE_TOP_DEFINES_SVH
// Checks that a condition implies a consequence on the same edge.
`define RTQ_ASSERT_IMP(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rtq check failed");
// Checks that a condition implies a consequence on the next edge.
`define RTQ_ASSERT_NXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rtq check failed");
`endif

// ----- rtl/core/rtq_pkg.sv -----
// ----------------------------------------------------------------------------
// rtq_pkg
// Shared types and codes for the repeating timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rtq_pkg;
  localparam int DueW = 48;
  localparam int PerW = 32;
  localparam int CntW = 17;
  localparam int IdW  = 8;
  localparam int OrdW = 16;

  localparam logic [1:0] EV_ADDED    = 2'd0;
  localparam logic [1:0] EV_REJECTED = 2'd1;
  localparam logic [1:0] EV_FIRED    = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [DueW-1:0] due;
    logic [PerW-1:0] period;
    logic [CntW-1:0] count;
    logic [IdW-1:0]  ident;
    logic [OrdW-1:0] order;
  } slot_t;

  // Candidate travelling down the chain during a search.
  typedef struct packed {
    logic             found;
    logic [DueW-1:0]  due;
    logic [OrdW-1:0]  age;
    logic [7:0]       idx;
  } cand_t;
endpackage

// ----- rtl/core/rtq_cell.sv -----
// ----------------------------------------------------------------------------
// rtq_cell
// One timer slot: holds a timer and compares it against the passing candidate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rtq_cell
  import rtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  my_idx,
  input  logic        wr_en,
  input  slot_t       wr_slot,
  input  logic [DueW-1:0] now,
  input  logic [OrdW-1:0] seq,
  input  cand_t       cand_in,
  output cand_t       cand_out,
  output slot_t       slot
);
  logic [OrdW-1:0] age;
  logic            elig;
  logic            win;

  assign age  = seq - slot.order;
  assign elig = slot.valid && (slot.due <= now);
  assign win  = elig && (!cand_in.found || slot.due < cand_in.due ||
                (slot.due == cand_in.due && age > cand_in.age));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (wr_en) begin
      slot <= wr_slot;
    end
  end

  // Register the handoff to the neighbor: one cell per cycle.
  always_ff @(posedge clk) begin
    if (win) begin
      cand_out <= '{found: 1'b1, due: slot.due, age: age, idx: my_idx};
    end else begin
      cand_out <= cand_in;
    end
  end
endmodule

// ----- rtl/core/repeating_timer_queue_top.sv -----
// ----------------------------------------------------------------------------
// repeating_timer_queue_top
// Ordered table of repeating timers with add and tick requests.
// ----------------------------------------------------------------------------
// An add request takes the lowest free slot and answers with one result
// (added or rejected) that is offered in the cycle right after the request
// is accepted. A tick request repeatedly searches the row of TIMER_SLOTS
// cells for the earliest due timer: the candidate walks the chain one cell
// per cycle through the search state, then an update state follows. A fire
// passes through an output state, while a zero-count timer is removed
// silently. The final search that finds nothing due ends in a closing
// state; a stalled result receiver stretches the output states. Requests
// are handled one at a time; s_tready is high only while the block is idle
// and the result register is empty.
`timescale 1ns / 1ps
`include "repeating_timer_queue_top_defines.svh"
module repeating_timer_queue_top
  import rtq_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  parameter int MAX_FIRES   = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // now[47:0], timer_id, first_due, period, repeats, zero pad
  input  logic         s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // event_res[1:0], fired_id, due_time, zero pad
  output logic         m_tlast   // last
);
  localparam int FW = $clog2(MAX_FIRES + 1);
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 2);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state;
  logic [CW-1:0]   cnt;
  logic [FW-1:0]   nfire;
  logic [OrdW-1:0] seq;
  logic [DueW-1:0] now;
  logic            have_out;      // a fire result waits to be emitted
  logic [IdW-1:0]  pend_id;
  logic [DueW-1:0] pend_due;
  logic [DueW-1:0] cur_due;       // due time of the winner before its update

  slot_t slots   [TIMER_SLOTS];
  cand_t chain   [TIMER_SLOTS+1];
  logic  wr_en   [TIMER_SLOTS];
  slot_t wr_slot;
  logic [SW-1:0] wr_idx;
  logic  wr_go;

  // Add request fields.
  logic [IdW-1:0]  a_id;
  logic [DueW-1:0] a_due;
  logic [PerW-1:0] a_per;
  logic [CntW-1:0] a_cnt;
  assign a_id  = s_tdata[55:48];
  assign a_due = s_tdata[103:56];
  assign a_per = s_tdata[135:104];
  assign a_cnt = s_tdata[152:136];

  logic in_acc, out_acc;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = m_tvalid && m_tready;

  // A waiting fire result is loaded into the output register this cycle.
  logic load_out;
  assign load_out = have_out && (!m_tvalid || out_acc) &&
                    (state == ST_OUT || state == ST_DONE);

  // Lowest free slot.
  logic          free_ok;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!slots[i].valid) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign chain[0] = '{found: 1'b0, due: '0, age: '0, idx: '0};

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    assign wr_en[g] = wr_go && (wr_idx == SW'(g));
    rtq_cell u_cell (
      .clk(clk), .rst(rst), .my_idx(8'(g)), .wr_en(wr_en[g]), .wr_slot(wr_slot),
      .now(now), .seq(seq), .cand_in(chain[g]), .cand_out(chain[g+1]),
      .slot(slots[g])
    );
  end

  // Update of the winning slot.
  cand_t           best;
  slot_t           bs;
  logic [DueW:0]   nd_sum;
  logic [CntW-1:0] ncnt;
  assign best   = chain[TIMER_SLOTS];
  assign bs     = slots[best.idx[SW-1:0]];
  assign nd_sum = {1'b0, bs.due} + {{(DueW-PerW+1){1'b0}}, bs.period};
  assign ncnt   = ($signed(bs.count) > 0) ? bs.count - 1'b1 : bs.count;

  always_comb begin
    wr_go   = 1'b0;
    wr_idx  = best.idx[SW-1:0];
    wr_slot = bs;
    if (state == ST_IDLE && in_acc && !s_tuser) begin
      wr_go   = free_ok;
      wr_idx  = free_idx;
      wr_slot = '{valid: 1'b1, due: a_due, period: a_per, count: a_cnt,
                  ident: a_id, order: seq};
    end else if (state == ST_UPD && best.found) begin
      wr_go = 1'b1;
      if (bs.count == '0) begin
        wr_slot.valid = 1'b0;
      end else begin
        wr_slot.due   = nd_sum[DueW] ? {DueW{1'b1}} : nd_sum[DueW-1:0];
        wr_slot.count = ncnt;
        wr_slot.valid = (ncnt != '0);
        wr_slot.order = seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seq      <= '0;
      m_tvalid <= 1'b0;
      have_out <= 1'b0;
      cnt      <= '0;
      nfire    <= '0;
    end else begin
      if (out_acc && !load_out) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (!s_tuser) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {6'd0, a_due, a_id, free_ok ? EV_ADDED : EV_REJECTED};
              m_tlast  <= 1'b1;
              if (free_ok) begin
                seq <= seq + 1'b1;
              end
            end else begin
              now      <= s_tdata[47:0];
              nfire    <= '0;
              have_out <= 1'b0;
              cnt      <= '0;
              state    <= ST_SRCH;
            end
          end
        end
        ST_SRCH: begin
          if (cnt == CW'(TIMER_SLOTS)) begin
            state <= ST_UPD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_UPD: begin
          cnt     <= '0;
          cur_due <= bs.due;
          if (!best.found) begin
            state <= ST_DONE;
          end else if (bs.count == '0) begin
            state <= (nfire == FW'(MAX_FIRES)) ? ST_DONE : ST_SRCH;
          end else begin
            if (ncnt != '0) begin
              seq <= seq + 1'b1;
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the previous fire until the next is known, for tlast.
          if (!m_tvalid || out_acc) begin
            if (have_out) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {6'd0, pend_due, pend_id, EV_FIRED};
              m_tlast  <= 1'b0;
            end
            have_out <= 1'b1;
            pend_id  <= bs.ident;
            pend_due <= cur_due;
            nfire    <= nfire + 1'b1;
            state    <= (nfire + 1'b1 == FW'(MAX_FIRES)) ? ST_DONE : ST_SRCH;
          end
        end
        ST_DONE: begin
          if (!have_out) begin
            state <= ST_IDLE;
          end else if (!m_tvalid || out_acc) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, pend_due, pend_id, EV_FIRED};
            m_tlast  <= 1'b1;
            have_out <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `RTQ_ASSERT_IMP(a_fire_bound, clk, rst, 1'b1, nfire <= FW'(MAX_FIRES))
  `RTQ_ASSERT_IMP(a_no_take_busy, clk, rst, state != ST_IDLE, !s_tready)
  `RTQ_ASSERT_NXT(a_add_answers, clk, rst, in_acc && !s_tuser, m_tvalid && m_tlast)
endmodule
